// ----- sv/chte_pkg.sv -----
// Shared types and constants for the chained hash table engine.
// No dependencies; every other file but chte_ram imports this package.
package chte_pkg;

	// Default parameter values for the top level
	localparam int SLOTS_DEF        = 64;
	localparam int BUCKET_DEPTH_DEF = 8;
	localparam int VALUE_WIDTH_DEF  = 32;
	localparam int MAX_KEY_LEN_DEF  = 256;

	// Hash arithmetic
	localparam int          HASH_W    = 32;
	localparam int          PORT_W    = 32;
	localparam logic [31:0] HASH_SEED = 32'd7;
	localparam int          HASH_MULT = 31;

	// Request codes
	localparam logic REQ_PUT = 1'b0;
	localparam logic REQ_GET = 1'b1;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_TOO_LONG = 3'd1,
		ST_EXISTS   = 3'd2,
		ST_NO_ITEM  = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	// Key fold outcome including the byte of the current transaction
	typedef struct packed {
		logic [HASH_W-1:0] hash;
		logic              overlong;
	} fold_t;

endpackage

// ----- sv/chte_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module chte_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/chte_keyfold.sv -----
// Key byte folding: running hash, byte position and overlong flag.
// Depends on chte_pkg.
module chte_keyfold import chte_pkg::*; #(
	parameter int MAX_KEY_LEN = MAX_KEY_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic       byte_present,
	input  logic [7:0] key_byte,
	input  logic       key_last,
	output fold_t      fold
);

	localparam int PW  = $clog2(MAX_KEY_LEN + 1);
	localparam int MW  = PW + 5;
	localparam logic [PW-1:0] MAX_POS = PW'(MAX_KEY_LEN);

	logic [HASH_W-1:0] hash_q;
	logic [PW-1:0]     pos_q;
	logic [MW-1:0]     pos31_q;   // position times the hash multiplier
	logic              overlong_q;
	logic              fold_byte;
	logic [MW+7:0]     term;

	// Fold the current byte unless the key has already reached its limit
	assign fold_byte = byte_present && (pos_q < MAX_POS);
	assign term      = (MW+8)'(key_byte) * (MW+8)'(pos31_q);

	always_comb begin
		fold.hash     = hash_q;
		fold.overlong = overlong_q;
		if (byte_present) begin
			if (fold_byte) begin
				fold.hash = hash_q + HASH_W'(term);
			end else begin
				fold.overlong = 1'b1;
			end
		end
	end

	// Advance on every accepted transaction, restart after the key ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q     <= HASH_SEED;
			pos_q      <= '0;
			pos31_q    <= '0;
			overlong_q <= 1'b0;
		end else if (accept) begin
			if (key_last) begin
				hash_q     <= HASH_SEED;
				pos_q      <= '0;
				pos31_q    <= '0;
				overlong_q <= 1'b0;
			end else begin
				hash_q     <= fold.hash;
				overlong_q <= fold.overlong;
				if (fold_byte) begin
					pos_q   <= pos_q + PW'(1);
					pos31_q <= pos31_q + MW'(HASH_MULT);
				end
			end
		end
	end

endmodule

// ----- sv/chte_moddiv.sv -----
// Bucket index unit: hash modulo SLOTS by a folded reciprocal multiply.
// Depends on chte_pkg.
module chte_moddiv import chte_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [HASH_W-1:0]        dividend,
	output logic                     done,
	output logic [$clog2(SLOTS)-1:0] remainder
);

	localparam int BW     = $clog2(SLOTS);
	localparam int RW     = 28;          // folded dividend stays below 2^16 * 4096
	localparam int SH     = RW + BW;
	localparam int PRW    = RW + 29;     // reciprocal fits in 29 bits
	localparam int FOLD_C = (1 << 16) % SLOTS;
	localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);

	logic [HASH_W-1:0] h_s1;
	logic              v_s1;
	logic [RW-1:0]     r1_s2;
	logic              v_s2;
	logic [RW-1:0]     r1_s3;
	logic [RW-1:0]     q_s3;
	logic              v_s3;
	logic [BW-1:0]     rem_q;
	logic              done_q;
	logic [RW-1:0]     r1_next;
	logic [PRW-1:0]    prod;
	logic [RW-1:0]     rem_full;

	// Fold the upper half down with 2^16 mod SLOTS, keeping the same remainder
	assign r1_next  = RW'(h_s1[HASH_W-1:16]) * RW'(FOLD_C) + RW'(h_s1[15:0]);
	// Quotient estimate by reciprocal, exact for every folded value
	assign prod     = PRW'(r1_s2) * PRW'(RECIP);
	// Subtract quotient times slot count
	assign rem_full = r1_s3 - q_s3 * RW'(SLOTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_s1   <= '0;
			v_s1   <= 1'b0;
			r1_s2  <= '0;
			v_s2   <= 1'b0;
			r1_s3  <= '0;
			q_s3   <= '0;
			v_s3   <= 1'b0;
			rem_q  <= '0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			done_q <= v_s3;
			if (start) begin
				h_s1 <= dividend;
			end
			r1_s2 <= r1_next;
			r1_s3 <= r1_s2;
			q_s3  <= RW'(prod >> SH);
			// Hold the remainder until the next request
			if (v_s3) begin
				rem_q <= rem_full[BW-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ----- sv/chained_hash_table_engine.sv -----
// Chained hash table engine: key bytes are taken one per cycle while busy is low and
// folded into a 32-bit hash. The transaction that ends a key within the length
// limit raises busy for the lookup, which scans at most BUCKET_DEPTH bucket entries:
// the hash is reduced modulo SLOTS, the bucket fill is read, then one entry is read per
// cycle from the entry memory, stopping at the first matching hash. An overlong key
// answers the next cycle without a lookup. Each result appears on status, read_value,
// collisions and entries_used for one cycle with done high; the receiver cannot stall it.
// After reset, busy stays high while the bucket fill memory is cleared.
module chained_hash_table_engine import chte_pkg::*; #(
	parameter int SLOTS        = SLOTS_DEF,
	parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF,
	parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF,
	parameter int MAX_KEY_LEN  = MAX_KEY_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              req_type,
	input  logic              byte_present,
	input  logic [7:0]        key_byte,
	input  logic              key_last,
	input  logic [PORT_W-1:0] put_value,
	output logic              done,
	output logic [2:0]        status,
	output logic [PORT_W-1:0] read_value,
	output logic [3:0]        collisions,
	output logic [9:0]        entries_used
);

	localparam int BW      = $clog2(SLOTS);
	localparam int FW      = $clog2(BUCKET_DEPTH + 1);
	localparam int ENTRIES = SLOTS * BUCKET_DEPTH;
	localparam int EAW     = $clog2(ENTRIES);
	localparam int VW      = VALUE_WIDTH;
	localparam int EW      = HASH_W + VW;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_FILL,
		S_SCAN
	} state_t;

	state_t            state_q;
	logic [BW-1:0]     clr_q;
	logic [HASH_W-1:0] hash_q;
	logic              req_q;
	logic [VW-1:0]     val_q;
	logic [BW-1:0]     bucket_q;
	logic [EAW-1:0]    base_q;
	logic [FW-1:0]     fill_q;
	logic [FW-1:0]     idx_q;
	logic [9:0]        total_q;
	logic              done_q;
	status_t           status_q;
	logic [PORT_W-1:0] read_q;
	logic [3:0]        coll_q;

	logic              accept;
	fold_t             fold;
	logic              div_start;
	logic              div_done;
	logic [BW-1:0]     div_rem;
	logic              fill_we;
	logic [BW-1:0]     fill_waddr;
	logic [FW-1:0]     fill_wdata;
	logic [FW-1:0]     fill_rdata;
	logic              ent_we;
	logic [EAW-1:0]    ent_waddr;
	logic [EAW-1:0]    ent_raddr;
	logic [EW-1:0]     ent_rdata;
	logic [FW-1:0]     cur_fill;
	logic [FW-1:0]     idx_next;
	logic              scan_hit;
	logic              finish;
	logic              put_ok;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// Key folding
	chte_keyfold #(
		.MAX_KEY_LEN (MAX_KEY_LEN)
	) u_keyfold (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.byte_present (byte_present),
		.key_byte     (key_byte),
		.key_last     (key_last),
		.fold         (fold)
	);

	// Bucket selection
	assign div_start = accept && key_last && !fold.overlong;

	chte_moddiv #(
		.SLOTS (SLOTS)
	) u_moddiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (fold.hash),
		.done      (div_done),
		.remainder (div_rem)
	);

	// Lookup decision: fill arrives in S_FILL, one entry per cycle in S_SCAN
	assign cur_fill = (state_q == S_FILL) ? fill_rdata : fill_q;
	assign idx_next = idx_q + FW'(1);
	assign scan_hit = (state_q == S_SCAN) && (ent_rdata[EW-1:VW] == hash_q);

	always_comb begin
		finish = 1'b0;
		case (state_q)
			S_FILL:  finish = (fill_rdata == '0);
			S_SCAN:  finish = scan_hit || (idx_next == fill_q);
			default: finish = 1'b0;
		endcase
	end

	assign put_ok = finish && !scan_hit && (req_q == REQ_PUT) &&
		(cur_fill < FW'(BUCKET_DEPTH));

	// Bucket fill memory: cleared after reset, bumped by each stored put
	assign fill_we    = (state_q == S_CLEAR) || put_ok;
	assign fill_waddr = (state_q == S_CLEAR) ? clr_q : bucket_q;
	assign fill_wdata = (state_q == S_CLEAR) ? '0 : cur_fill + FW'(1);

	chte_ram #(
		.WIDTH (FW),
		.DEPTH (SLOTS)
	) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.raddr (div_rem),
		.rdata (fill_rdata)
	);

	// Entry memory: hash in the upper field, value in the lower
	assign ent_we    = put_ok;
	assign ent_waddr = base_q + EAW'(cur_fill);
	assign ent_raddr = (state_q == S_FILL) ? base_q : base_q + EAW'(idx_next);

	chte_ram #(
		.WIDTH (EW),
		.DEPTH (ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata ({hash_q, val_q}),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	// Sequencer with registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			hash_q   <= HASH_SEED;
			req_q    <= REQ_PUT;
			val_q    <= '0;
			bucket_q <= '0;
			base_q   <= '0;
			fill_q   <= '0;
			idx_q    <= '0;
			total_q  <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			read_q   <= '0;
			coll_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + BW'(1);
					if (clr_q == BW'(SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept && key_last) begin
						hash_q <= fold.hash;
						req_q  <= req_type;
						val_q  <= VW'(put_value);
						if (fold.overlong) begin
							done_q   <= 1'b1;
							status_q <= ST_TOO_LONG;
							read_q   <= '0;
							coll_q   <= '0;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						bucket_q <= div_rem;
						base_q   <= EAW'(div_rem) * EAW'(BUCKET_DEPTH);
						state_q  <= S_FILL;
					end
				end
				S_FILL, S_SCAN: begin
					if (state_q == S_FILL) begin
						fill_q <= fill_rdata;
						idx_q  <= '0;
						state_q <= S_SCAN;
					end else begin
						idx_q <= idx_next;
					end
					if (finish) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						read_q  <= '0;
						coll_q  <= (req_q == REQ_PUT) ? 4'(cur_fill) : 4'd0;
						if (scan_hit) begin
							if (req_q == REQ_PUT) begin
								status_q <= ST_EXISTS;
							end else begin
								status_q <= ST_OK;
								read_q   <= PORT_W'(ent_rdata[VW-1:0]);
							end
						end else if (req_q == REQ_GET) begin
							status_q <= ST_NO_ITEM;
						end else if (put_ok) begin
							status_q <= ST_OK;
							total_q  <= total_q + 10'd1;
						end else begin
							status_q <= ST_FULL;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign read_value   = read_q;
	assign collisions   = coll_q;
	assign entries_used = total_q;

	// Scan never reads past the filled part of the bucket
	a_scan_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (idx_q < fill_q))
		else $error("bucket scan index beyond fill");

	// A stored put always lands in a free bucket entry
	a_put_room: assert property (@(posedge clk) disable iff (!arst_n)
		put_ok |-> (cur_fill < FW'(BUCKET_DEPTH)))
		else $error("put stored into a full bucket");

	// Entry count follows each stored put
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		put_ok |=> (total_q == $past(total_q) + 10'd1))
		else $error("entry count did not advance");

	// Results only come out with the sequencer back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result strobe outside idle");

	// The modulo unit finishes only while the sequencer waits for it
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("modulo result with no lookup pending");

endmodule
